// ----- rtl/core/jvsm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jvsm_pkg: shared types and constants of the joystick velocity mapper
// command codes, register indexes, reset values and channel select bundle
// ----------------------------------------------------------------------------
package jvsm_pkg;

   localparam int NUM_CHANNELS     = 6;
   localparam int CHAN_PER_GROUP   = 3;
   localparam int MAP_W            = 15;
   localparam int GROUP_MAP_W      = MAP_W * CHAN_PER_GROUP;
   localparam int VEL_W            = 16;
   localparam int SCALE_W          = 15;
   localparam int TIMEOUT_W        = 16;
   localparam int SLOT_W           = 4;
   localparam int CMD_W            = 2;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = GROUP_MAP_W;
   localparam int REQ_DATA_W       = 24;
   localparam int RSP_DATA_W       = VEL_W * NUM_CHANNELS;

   localparam int AXIS_SLOTS_DEF   = 8;
   localparam int BUTTON_SLOTS_DEF = 16;

   // command codes carried on tuser
   localparam logic [CMD_W-1:0] CMD_AXIS   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_LINEAR_MAP   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGULAR_MAP  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LINEAR_SCALE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGULAR_SCALE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LINEAR_STEP  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGULAR_STEP = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_TIMEOUT      = 3'd6;

   // register reset values
   localparam logic [SCALE_W-1:0]   LINEAR_SCALE_RST  = 15'd819;
   localparam logic [SCALE_W-1:0]   ANGULAR_SCALE_RST = 15'd410;
   localparam logic [SCALE_W-1:0]   LINEAR_STEP_RST   = 15'd205;
   localparam logic [SCALE_W-1:0]   ANGULAR_STEP_RST  = 15'd51;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST       = 16'd10;
   localparam logic [TIMEOUT_W-1:0] AGE_MAX           = 16'hFFFF;

   typedef logic [MAP_W-1:0]        map_type;
   typedef logic signed [VEL_W-1:0] vel_type;

   // resolved joystick inputs of one channel
   typedef struct packed {
      logic signed [VEL_W-1:0] axis;   // zero when unmapped or out of range
      logic                    pos_en; // positive button mapped
      logic                    pos_on; // mapped positive button pressed
      logic                    neg_on; // mapped negative button pressed
   } sel_type;

endpackage
`default_nettype wire

// ----- rtl/core/jvsm_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jvsm_store: joystick element store and message age tracking
// holds axis and button values, resolves each channel's mapped inputs
// ----------------------------------------------------------------------------
module jvsm_store #(
   parameter int AXIS_SLOTS   = jvsm_pkg::AXIS_SLOTS_DEF,
   parameter int BUTTON_SLOTS = jvsm_pkg::BUTTON_SLOTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              elem_en,
   input  wire logic                              tick_en,
   input  wire logic [jvsm_pkg::CMD_W-1:0]        cmd,
   input  wire logic [jvsm_pkg::SLOT_W-1:0]       slot,
   input  wire logic signed [jvsm_pkg::VEL_W-1:0] value,
   input  wire logic                              last,
   input  wire jvsm_pkg::map_type                 maps [jvsm_pkg::NUM_CHANNELS],
   input  wire logic [jvsm_pkg::TIMEOUT_W-1:0]    timeout,
   output jvsm_pkg::sel_type                      sel [jvsm_pkg::NUM_CHANNELS],
   output logic                                   fresh
);
   import jvsm_pkg::*;

   localparam int AIW = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1;
   localparam int BIW = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;
   localparam logic [SLOT_W:0] AXIS_LIM   = (SLOT_W+1)'(AXIS_SLOTS);
   localparam logic [SLOT_W:0] BUTTON_LIM = (SLOT_W+1)'(BUTTON_SLOTS);

   vel_type                  axis_ff [AXIS_SLOTS];
   logic [BUTTON_SLOTS-1:0]  button_ff;
   logic [TIMEOUT_W-1:0]     age_ff, age_in;
   logic                     seen_ff, seen_in;
   logic                     axis_wr, button_wr;

   assign axis_wr   = elem_en && (cmd == CMD_AXIS) && ({1'b0, slot} < AXIS_LIM);
   assign button_wr = elem_en && (cmd == CMD_BUTTON) && ({1'b0, slot} < BUTTON_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_SLOTS; i++) axis_ff[i] <= '0;
         button_ff <= '0;
      end else begin
         if (axis_wr) axis_ff[slot[AIW-1:0]] <= value;
         if (button_wr) button_ff[slot[BIW-1:0]] <= (value != '0);
      end
   end

   // fresh test uses the age before this tick's increment
   assign fresh = seen_ff && (age_ff < timeout);

   always_comb begin
      age_in  = age_ff;
      seen_in = seen_ff;
      if (elem_en && last) begin
         age_in  = '0;
         seen_in = 1'b1;
      end else if (tick_en && (age_ff != AGE_MAX)) begin
         age_in = age_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff  <= AGE_MAX;
         seen_ff <= 1'b0;
      end else begin
         age_ff  <= age_in;
         seen_ff <= seen_in;
      end
   end

   // per channel lookup of mapped axis and buttons
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_sel
      logic [4:0] am, pm, nm;
      logic       a_ok, p_ok, n_ok;
      assign am   = maps[c][4:0];
      assign pm   = maps[c][9:5];
      assign nm   = maps[c][14:10];
      assign a_ok = am[4] && ({1'b0, am[3:0]} < AXIS_LIM);
      assign p_ok = pm[4] && ({1'b0, pm[3:0]} < BUTTON_LIM);
      assign n_ok = nm[4] && ({1'b0, nm[3:0]} < BUTTON_LIM);
      assign sel[c].axis   = a_ok ? axis_ff[am[AIW-1:0]] : '0;
      assign sel[c].pos_en = pm[4];
      assign sel[c].pos_on = p_ok && button_ff[pm[BIW-1:0]];
      assign sel[c].neg_on = n_ok && button_ff[nm[BIW-1:0]];
   end

endmodule
`default_nettype wire

// ----- rtl/core/jvsm_channel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jvsm_channel: velocity datapath of one channel
// scale with rounding, button override, saturation and slew limiting
// ----------------------------------------------------------------------------
module jvsm_channel (
   input  wire jvsm_pkg::sel_type               sel,
   input  wire logic [jvsm_pkg::SCALE_W-1:0]    scale,
   input  wire logic [jvsm_pkg::SCALE_W-1:0]    step,
   input  wire logic signed [jvsm_pkg::VEL_W-1:0] prev,
   output logic signed [jvsm_pkg::VEL_W-1:0]    vel
);
   import jvsm_pkg::*;

   function automatic logic signed [VEL_W-1:0] sat16(input logic signed [17:0] x);
      if (x > 18'sd32767) return 16'sh7FFF;
      if (x < -18'sd32768) return 16'sh8000;
      return x[VEL_W-1:0];
   endfunction

   logic signed [31:0] prod;
   logic signed [31:0] rnd;
   logic signed [17:0] scaled;
   logic signed [17:0] scale_s;
   logic signed [17:0] v0, v1, v2, hi, lo;

   assign prod    = sel.axis * $signed({1'b0, scale});
   assign rnd     = prod + 32'sd16384;
   assign scaled  = 18'(rnd[31:15]) | {{1{rnd[31]}}, 17'd0};
   assign scale_s = $signed({3'b000, scale});
   assign hi      = 18'(prev) + $signed({3'b000, step});
   assign lo      = 18'(prev) - $signed({3'b000, step});

   always_comb begin
      v0 = 18'(sat16(scaled));
      if (sel.pos_en) v0 = sel.pos_on ? scale_s : '0;
      v1 = sel.neg_on ? 18'(sat16(v0 - scale_s)) : v0;
      v2 = v1;
      if (v2 > hi) v2 = hi;
      if (v2 < lo) v2 = lo;
      vel = sat16(v2);
   end

endmodule
`default_nettype wire

// ----- rtl/core/joystick_velocity_slew_mapper_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_velocity_slew_mapper_core: joystick to velocity command mapper
// turns joystick elements and ticks into six slew-limited velocity commands
// ----------------------------------------------------------------------------
// usage
//  - req channel: one word per joystick element or tick; tuser is the command
//    (axis write, button write, tick), tlast closes a joystick message
//  - element words update the store and give no rsp word; a tick gives one
//    rsp word with linear x,y,z and angular x,y,z velocities in Q4.12
//  - a word is registered in the input register and a tick then moves on into
//    the output register, which offers its rsp word; one word per cycle
//    sustained unless a tick waits behind a stalled rsp word, set by the
//    single pass datapath
//  - a stalled rsp word holds in the output register; the input register
//    still takes words and element words still pass, and req_tready drops only
//    when a tick waits behind a held rsp word
//  - csr channel is always ready; write only while the block is idle
//  - synchronous reset clears the store, sets message age to saturated,
//    clears previous velocities and loads register defaults; no clear pass
// ----------------------------------------------------------------------------
module joystick_velocity_slew_mapper_core #(
   parameter int AXIS_SLOTS   = jvsm_pkg::AXIS_SLOTS_DEF,
   parameter int BUTTON_SLOTS = jvsm_pkg::BUTTON_SLOTS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req word
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [jvsm_pkg::REQ_DATA_W-1:0]    req_tdata,  // slot[3:0], value[19:4]
   input  wire logic [jvsm_pkg::CMD_W-1:0]         req_tuser,  // cmd[1:0]
   input  wire logic                               req_tlast,  // last
   // rsp word
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [jvsm_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // lin x,y,z then ang x,y,z
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [jvsm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [jvsm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import jvsm_pkg::*;

   // configuration registers
   logic [GROUP_MAP_W-1:0] lin_map_ff, ang_map_ff;
   logic [SCALE_W-1:0]     lin_scale_ff, ang_scale_ff, lin_step_ff, ang_step_ff;
   logic [TIMEOUT_W-1:0]   timeout_ff;
   logic                   csr_wr;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]       cmd_ff;
   logic [SLOT_W-1:0]      slot_ff;
   vel_type                value_ff;
   logic                   last_ff;

   // output register and velocity history
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]  out_data_ff;
   vel_type                prev_ff [NUM_CHANNELS];

   logic                   advance, is_tick, is_elem, req_take, fresh;
   map_type                maps [NUM_CHANNELS];
   sel_type                sel [NUM_CHANNELS];
   vel_type                vel [NUM_CHANNELS];
   vel_type                vel_out [NUM_CHANNELS];

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_map_ff   <= '0;
         ang_map_ff   <= '0;
         lin_scale_ff <= LINEAR_SCALE_RST;
         ang_scale_ff <= ANGULAR_SCALE_RST;
         lin_step_ff  <= LINEAR_STEP_RST;
         ang_step_ff  <= ANGULAR_STEP_RST;
         timeout_ff   <= TIMEOUT_RST;
      end else if (csr_wr) begin
         case (csr_addr)
            REG_LINEAR_MAP:    lin_map_ff   <= csr_wdata;
            REG_ANGULAR_MAP:   ang_map_ff   <= csr_wdata;
            REG_LINEAR_SCALE:  lin_scale_ff <= csr_wdata[SCALE_W-1:0];
            REG_ANGULAR_SCALE: ang_scale_ff <= csr_wdata[SCALE_W-1:0];
            REG_LINEAR_STEP:   lin_step_ff  <= csr_wdata[SCALE_W-1:0];
            REG_ANGULAR_STEP:  ang_step_ff  <= csr_wdata[SCALE_W-1:0];
            REG_TIMEOUT:       timeout_ff   <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // only a tick needs room in the output register
   assign is_tick    = (cmd_ff == CMD_TICK);
   assign is_elem    = (cmd_ff == CMD_AXIS) || (cmd_ff == CMD_BUTTON);
   assign advance    = in_valid_ff && (!is_tick || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= req_tuser;
         slot_ff  <= req_tdata[SLOT_W-1:0];
         value_ff <= req_tdata[SLOT_W+VEL_W-1:SLOT_W];
         last_ff  <= req_tlast;
      end
   end

   for (genvar c = 0; c < CHAN_PER_GROUP; c++) begin : g_maps
      assign maps[c]                  = lin_map_ff[c*MAP_W +: MAP_W];
      assign maps[c + CHAN_PER_GROUP] = ang_map_ff[c*MAP_W +: MAP_W];
   end

   jvsm_store #(
      .AXIS_SLOTS   (AXIS_SLOTS),
      .BUTTON_SLOTS (BUTTON_SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .elem_en (advance && is_elem),
      .tick_en (advance && is_tick),
      .cmd     (cmd_ff),
      .slot    (slot_ff),
      .value   (value_ff),
      .last    (last_ff),
      .maps    (maps),
      .timeout (timeout_ff),
      .sel     (sel),
      .fresh   (fresh)
   );

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      localparam bit LIN = (c < CHAN_PER_GROUP);
      jvsm_channel u_chan (
         .sel   (sel[c]),
         .scale (LIN ? lin_scale_ff : ang_scale_ff),
         .step  (LIN ? lin_step_ff : ang_step_ff),
         .prev  (prev_ff[c]),
         .vel   (vel[c])
      );
      // stale or missing message forces zero, history follows the output
      assign vel_out[c] = fresh ? vel[c] : '0;
   end

   assign out_valid_in = (advance && is_tick) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) prev_ff[i] <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance && is_tick) begin
            for (int i = 0; i < NUM_CHANNELS; i++) prev_ff[i] <= vel_out[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_tick) begin
         for (int i = 0; i < NUM_CHANNELS; i++) out_data_ff[i*VEL_W +: VEL_W] <= vel_out[i];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/jvsm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jvsm_checker: port level checks of the joystick velocity mapper
// reset, stall hold, tick latency and back pressure cause
// ----------------------------------------------------------------------------
module jvsm_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [jvsm_pkg::CMD_W-1:0]       req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [jvsm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import jvsm_pkg::*;

   // no rsp word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word valid after reset");

   // a held rsp word keeps its data
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // a tick reaches the output through the input register when there is room
   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_TICK)
      ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("tick did not produce rsp word");

   // back pressure only comes from a stalled rsp word
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without rsp stall");

endmodule

bind joystick_velocity_slew_mapper_core jvsm_checker u_checker (.*);
`default_nettype wire
